@@ rtl/avtp_audio_depacketizer_unit_assert.svh @@
// Assertion macros for the AVTP audio depacketizer
`ifndef AVTP_AUDIO_DEPACKETIZER_UNIT_ASSERT_SVH
`define AVTP_AUDIO_DEPACKETIZER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AVTP_ADP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AVTP_ADP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/avtp_adp_pkg.sv @@
// Shared types and constants for the AVTP audio depacketizer
package avtp_adp_pkg;

    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX      = 11'd2047;
    localparam logic [POS_W-1:0] ETYPE_HI_POS = 11'd16;
    localparam logic [POS_W-1:0] ETYPE_LO_POS = 11'd17;
    localparam logic [POS_W-1:0] SID_FIRST_POS = 11'd22;
    localparam logic [POS_W-1:0] SID_LAST_POS  = 11'd29;

    localparam int SAMPLE_W = 24;
    localparam logic [SAMPLE_W-1:0] PCM_MASK = 24'hFF_FFFF;

    localparam logic [7:0] ETYPE_RESET_HI = 8'h22;
    localparam logic [7:0] ETYPE_RESET_LO = 8'hF0;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ETHER_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TALKER_SID = 2'd1;

    localparam logic [1:0] PHASE_LABEL = 2'd0;
    localparam logic [1:0] PHASE_MSB   = 2'd1;
    localparam logic [1:0] PHASE_MID   = 2'd2;
    localparam logic [1:0] PHASE_LSB   = 2'd3;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [63:0] talker_sid;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] audio_sample;
        logic                       channel_number;
        logic [2:0]                 sample_number;
        logic                       last_in_packet;
    } result_t;

endpackage

@@ rtl/avtp_adp_cfg_regs.sv @@
// Configuration registers: expected ethertype and stream ID
module avtp_adp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [avtp_adp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [avtp_adp_pkg::CFG_DATA_W-1:0] cfg_data,
    output avtp_adp_pkg::cfg_t                  cfg
);
    import avtp_adp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_ETHER_TYPE: cfg_next.ether_type = cfg_data[15:0];
                CFG_IDX_TALKER_SID: cfg_next.talker_sid = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ether_type <= {ETYPE_RESET_HI, ETYPE_RESET_LO};
            cfg_reg.talker_sid <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/avtp_adp_core.sv @@
// Frame parser: byte position, header match, sample assembly and indexing
module avtp_adp_core #(
    parameter int CHANNEL_COUNT      = 2,
    parameter int SAMPLES_PER_PACKET = 6,
    parameter int PAYLOAD_OFFSET     = 50
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_frame,
    input  avtp_adp_pkg::cfg_t    cfg,
    output logic                  res_valid,
    output avtp_adp_pkg::result_t res
);
    import avtp_adp_pkg::*;

    localparam int WORDS   = CHANNEL_COUNT * SAMPLES_PER_PACKET;
    localparam int PAY_END = PAYLOAD_OFFSET + 4 * WORDS;
    localparam int CW      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int SW      = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
    localparam logic [CW-1:0] CH_LAST  = CW'(CHANNEL_COUNT - 1);
    localparam logic [SW-1:0] SMP_LAST = SW'(SAMPLES_PER_PACKET - 1);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                match_reg, match_next;
    logic [SAMPLE_W-1:0] asm_reg, asm_next;
    logic [CW-1:0]       ch_reg, ch_next;
    logic [SW-1:0]       smp_reg, smp_next;

    logic                in_payload;
    logic [POS_W-1:0]    rel;
    logic [1:0]          phase;
    logic [2:0]          sid_idx;
    logic [7:0]          sid_byte;
    logic [SAMPLE_W-1:0] sample;
    logic                emit;
    logic [SW+2:0]       smp_ext;

    assign in_payload = ({1'b0, pos_reg} >= 12'(PAYLOAD_OFFSET))
                     && ({1'b0, pos_reg} < 12'(PAY_END))
                     && (pos_reg != POS_MAX);
    assign rel      = pos_reg - POS_W'(PAYLOAD_OFFSET);
    assign phase    = rel[1:0];
    assign sid_idx  = 3'(pos_reg - SID_FIRST_POS);
    assign sid_byte = cfg.talker_sid[63 - 8 * sid_idx -: 8];
    assign sample   = (asm_reg | {16'h0000, data_byte}) & PCM_MASK;
    assign smp_ext  = {3'b000, smp_reg};

    always_comb
    begin
        pos_next   = pos_reg;
        match_next = match_reg;
        asm_next   = asm_reg;
        ch_next    = ch_reg;
        smp_next   = smp_reg;
        emit       = 1'b0;

        priority if (pos_reg == ETYPE_HI_POS)
        begin
            if (data_byte != cfg.ether_type[15:8])
                match_next = 1'b0;
        end
        else if (pos_reg == ETYPE_LO_POS)
        begin
            if (data_byte != cfg.ether_type[7:0])
                match_next = 1'b0;
        end
        else if (pos_reg >= SID_FIRST_POS && pos_reg <= SID_LAST_POS)
        begin
            if (data_byte != sid_byte)
                match_next = 1'b0;
        end
        else if (in_payload)
        begin
            unique case (phase)
                PHASE_MSB: asm_next = {data_byte, 16'h0000};
                PHASE_MID: asm_next = (asm_reg | {8'h00, data_byte, 8'h00}) & PCM_MASK;
                PHASE_LSB:
                begin
                    asm_next = '0;
                    emit     = match_reg;
                    if (ch_reg == CH_LAST)
                    begin
                        ch_next  = '0;
                        smp_next = smp_reg + 1'b1;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
                PHASE_LABEL: asm_next = '0;
            endcase
        end
        else
        begin
            asm_next = asm_reg;
        end

        if (end_of_frame)
        begin
            pos_next   = '0;
            match_next = 1'b1;
            asm_next   = '0;
            ch_next    = '0;
            smp_next   = '0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            match_reg <= 1'b1;
            asm_reg   <= '0;
            ch_reg    <= '0;
            smp_reg   <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            match_reg <= match_next;
            asm_reg   <= asm_next;
            ch_reg    <= ch_next;
            smp_reg   <= smp_next;
        end
    end

    assign res_valid          = step && emit;
    assign res.audio_sample   = sample;
    assign res.channel_number = ch_reg[0];
    assign res.sample_number  = smp_ext[2:0];
    assign res.last_in_packet = (ch_reg == CH_LAST) && (smp_reg == SMP_LAST);

endmodule

@@ rtl/avtp_adp_out_reg.sv @@
// Result register on the output channel
module avtp_adp_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  avtp_adp_pkg::result_t res,
    input  logic                  out_ready,
    output logic                  out_valid,
    output avtp_adp_pkg::result_t out_res
);
    import avtp_adp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ rtl/avtp_audio_depacketizer_unit.sv @@
// AVTP audio depacketizer: one frame byte per transaction in, one PCM sample per word out.
// The block takes one byte per cycle as long as the output side keeps up; a byte is
// registered in the input register on entry and parsed as it advances from there, and
// any sample it completes is loaded into the result register as that byte advances.
// While a result waits in the result register, one more byte is held in the input
// register and further bytes stall until the result is taken. Ethertype (bytes 16-17)
// and stream ID (bytes 22-29) are compared against the configuration registers; a
// mismatch silences the whole frame.
`include "avtp_audio_depacketizer_unit_assert.svh"

module avtp_audio_depacketizer_unit #(
    parameter int CHANNEL_COUNT      = 2,
    parameter int SAMPLES_PER_PACKET = 6,
    parameter int PAYLOAD_OFFSET     = 50
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                end_of_frame,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [23:0]                  audio_sample,
    output logic                                channel_number,
    output logic [2:0]                          sample_number,
    output logic                                last_in_packet,
    input  logic                                cfg_write,
    input  logic [avtp_adp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [avtp_adp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import avtp_adp_pkg::*;

    localparam logic       LAST_CHANNEL = 1'((CHANNEL_COUNT - 1) % 2);
    localparam logic [2:0] LAST_SAMPLE  = 3'((SAMPLES_PER_PACKET - 1) % 8);

    cfg_t       cfg;
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_eof_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign advance  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        priority if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_eof_reg  <= end_of_frame;
        end
    end

    avtp_adp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    avtp_adp_core #(
        .CHANNEL_COUNT      (CHANNEL_COUNT),
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET),
        .PAYLOAD_OFFSET     (PAYLOAD_OFFSET)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (s1_byte_reg),
        .end_of_frame (s1_eof_reg),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res          (res)
    );

    avtp_adp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign audio_sample   = out_res.audio_sample;
    assign channel_number = out_res.channel_number;
    assign sample_number  = out_res.sample_number;
    assign last_in_packet = out_res.last_in_packet;

    `AVTP_ADP_ASSERT_NOW(a_stall_cause, !in_ready, s1_valid_reg && out_valid && !out_ready, "input stalled without a blocked result")
    `AVTP_ADP_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_eof_reg), "held byte lost or changed")
    `AVTP_ADP_ASSERT_NOW(a_last_index, out_valid && last_in_packet, channel_number == LAST_CHANNEL && sample_number == LAST_SAMPLE, "last sample carries wrong index")

endmodule
